// ----- design/fpsc_pkg.sv -----
// Package for the flash page store controller: opcodes, mode and error codes,
// status words, sizes, channel widths and the controller/datapath handshake structs.
// No dependencies.
package fpsc_pkg;

    // Sizes
    localparam int FLASH_BYTES_DEF = 131072;
    localparam int RDRAM_BYTES     = 8388608;
    localparam int PAGE_BYTES      = 128;
    localparam int PAGE_AW         = 7;
    localparam int STATUS_BYTES    = 8;

    // Channel widths
    localparam int S_TDATA_W = 152;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 96;

    // Cartridge bus base of the flash window
    localparam logic [31:0] CART_BASE = 32'h0800_0000;

    // Input item kinds (s_tuser)
    localparam logic [2:0] IN_COMMAND   = 3'd0;
    localparam logic [2:0] IN_STATUS_HI = 3'd1;
    localparam logic [2:0] IN_DMA_READ  = 3'd2;
    localparam logic [2:0] IN_DMA_WRITE = 3'd3;
    localparam logic [2:0] IN_PAGE_LOAD = 3'd4;

    // Command opcodes (top byte of the command word)
    localparam logic [7:0] OPC_SET_OFFSET   = 8'h4B;
    localparam logic [7:0] OPC_ERASE        = 8'h78;
    localparam logic [7:0] OPC_ERASE_OFFSET = 8'hA5;
    localparam logic [7:0] OPC_WRITE        = 8'hB4;
    localparam logic [7:0] OPC_EXECUTE      = 8'hD2;
    localparam logic [7:0] OPC_STATUS       = 8'hE1;
    localparam logic [7:0] OPC_READ         = 8'hF0;

    // Status words loaded by commands
    localparam logic [63:0] STAT_ERASE        = 64'h1111_8008_00C2_0000;
    localparam logic [63:0] STAT_ERASE_OFFSET = 64'h1111_8004_00C2_0000;
    localparam logic [63:0] STAT_STATUS       = 64'h1111_8001_00C2_0000;
    localparam logic [63:0] STAT_READ         = 64'h1111_8004_F000_0000;

    // Error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
    localparam logic [2:0] ERR_BAD_READ  = 3'd2;
    localparam logic [2:0] ERR_BAD_WRITE = 3'd3;
    localparam logic [2:0] ERR_EXEC_READ = 3'd4;
    localparam logic [2:0] ERR_RANGE     = 3'd5;

    // Operating mode
    typedef enum logic [2:0] {
        OPM_IDLE   = 3'd0,
        OPM_ERASE  = 3'd1,
        OPM_WRITE  = 3'd2,
        OPM_READ   = 3'd3,
        OPM_STATUS = 3'd4
    } opm_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic commit;
        logic exec_en;
        logic rd_capture;
    } fpsc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic need_exec;
        logic need_rd;
        logic exec_done;
    } fpsc_stat_t;

endpackage

// ----- design/flash_page_store_controller.sv -----
// Top level of the flash page store controller: controller plus datapath.
// Depends on fpsc_pkg, fpsc_ctrl, fpsc_dp (and fpsc_ram below it).
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the item kind on s_tuser
//   (command write, status high read, dma read byte, dma write start, page byte
//   load). Every accepted beat yields exactly one result beat on m_tvalid/m_tready.
//   Items are handled one at a time: accept, then decode in the next cycle, and
//   s_tready returns in the cycle after decode. A flash byte read also passes
//   through the RDWAIT state for the flash memory's registered read port.
//   An execute command returns its result at decode, then copies or erases the
//   page one byte a cycle, and takes no new item until the page is done.
//   After reset the flash is swept to 0xFF one byte a cycle; s_tready stays low
//   until then. All mode, status and pointer registers reset to zero/idle.
//   The result sits in an output register; while the receiver stalls, one more
//   item is still accepted and waits in decode until the output register drains.
module flash_page_store_controller #(
    parameter int FLASH_BYTES = fpsc_pkg::FLASH_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, low bit up: command_word[31:0], cart_address[63:32],
    // dram_address[87:64], length_minus_one[111:88], byte_index[135:112],
    // page_index[142:136], data_byte[150:143], zero pad [151]
    input  logic [fpsc_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode[2:0]
    input  logic [fpsc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, low bit up: data_out[63:0], dram_target[87:64],
    // store_enable[88], error_code[91:89], zero pad [95:92]
    output logic [fpsc_pkg::M_TDATA_W-1:0]  m_tdata
);

    fpsc_pkg::fpsc_cmd_t  cmd;
    fpsc_pkg::fpsc_stat_t stat;

    fpsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fpsc_dp #(
        .FLASH_BYTES(FLASH_BYTES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata)
    );

endmodule

// ----- design/fpsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/fpsc_ctrl.sv -----
// Controller state machine: clearing pass, item intake, decode, page execute, flash read.
// Depends on fpsc_pkg.
module fpsc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  fpsc_pkg::fpsc_stat_t   stat,
    output fpsc_pkg::fpsc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DECODE = 5'b00100,
        ST_EXEC   = 5'b01000,
        ST_RDWAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                // hold until the output register can take a beat
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    if (stat.need_exec) begin
                        state_next = ST_EXEC;
                    end else if (stat.need_rd) begin
                        state_next = ST_RDWAIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EXEC: begin
                cmd.exec_en = 1'b1;
                if (stat.exec_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RDWAIT: begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/fpsc_dp.sv -----
// Datapath: input register, command decode, mode/status/pointer registers,
// page buffer and flash memories, page copy counter, output register.
// Depends on fpsc_pkg and fpsc_ram.
module fpsc_dp #(
    parameter int FLASH_BYTES = fpsc_pkg::FLASH_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fpsc_pkg::fpsc_cmd_t             cmd,
    output fpsc_pkg::fpsc_stat_t            stat,
    input  logic [fpsc_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic [fpsc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [fpsc_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int FA = $clog2(FLASH_BYTES);
    localparam int PA = fpsc_pkg::PAGE_AW;
    localparam logic [24:0] FlashLim = 25'(FLASH_BYTES);
    localparam logic [24:0] PageLim  = 25'(FLASH_BYTES - fpsc_pkg::PAGE_BYTES);
    localparam logic [24:0] RdramLim = 25'(fpsc_pkg::RDRAM_BYTES);
    localparam logic [24:0] SrcLim   = 25'(fpsc_pkg::RDRAM_BYTES - fpsc_pkg::PAGE_BYTES);
    localparam logic [24:0] StatLim  = 25'(fpsc_pkg::RDRAM_BYTES - fpsc_pkg::STATUS_BYTES);

    // Input item register
    logic [2:0]  in_mode_reg;
    logic [31:0] cmd_word_reg;
    logic [31:0] cart_reg;
    logic [23:0] dram_reg;
    logic [23:0] lenm1_reg;
    logic [23:0] bidx_reg;
    logic [6:0]  pidx_reg;
    logic [7:0]  dbyte_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_mode_reg  <= s_tuser;
            cmd_word_reg <= s_tdata[31:0];
            cart_reg     <= s_tdata[63:32];
            dram_reg     <= s_tdata[87:64];
            lenm1_reg    <= s_tdata[111:88];
            bidx_reg     <= s_tdata[135:112];
            pidx_reg     <= s_tdata[142:136];
            dbyte_reg    <= s_tdata[150:143];
        end
    end

    // Controller state registers
    fpsc_pkg::opm_t op_mode_reg, op_mode_next;
    logic [63:0]    status_reg, status_next;
    logic [22:0]    page_off_reg, page_off_next;
    logic [23:0]    src_ptr_reg, src_ptr_next;

    // Bounds checks
    logic [7:0]  opcode;
    logic [22:0] po_cmd;
    logic        po_ok;
    logic        sp_ok;
    logic [31:0] cart_diff;
    logic [16:0] foff;
    logic [24:0] rd_sum_flash;
    logic [24:0] rd_sum_dram;
    logic        rd_ok;
    logic [23:0] rd_target;

    assign opcode       = cmd_word_reg[31:24];
    assign po_cmd       = {cmd_word_reg[15:0], {PA{1'b0}}};
    assign po_ok        = {2'b00, page_off_reg} <= PageLim;
    assign sp_ok        = {1'b0, src_ptr_reg} <= SrcLim;
    assign cart_diff    = cart_reg - fpsc_pkg::CART_BASE;
    assign foff         = {cart_diff[15:0], 1'b0};
    assign rd_sum_flash = 25'(foff) + 25'(bidx_reg);
    assign rd_sum_dram  = 25'(dram_reg) + 25'(bidx_reg);
    assign rd_target    = dram_reg + bidx_reg;
    // byte index inside the clamped transfer length
    assign rd_ok = (bidx_reg <= lenm1_reg) && (25'(foff) < FlashLim) &&
                   (rd_sum_flash < FlashLim) && ({1'b0, dram_reg} < RdramLim) &&
                   (rd_sum_dram < RdramLim);

    // Item decode
    logic        need_exec;
    logic        need_rd;
    logic        pb_we;
    logic [63:0] res_data;
    logic [23:0] res_target;
    logic        res_store;
    logic [2:0]  res_err;

    always_comb begin
        op_mode_next  = op_mode_reg;
        status_next   = status_reg;
        page_off_next = page_off_reg;
        src_ptr_next  = src_ptr_reg;
        need_exec     = 1'b0;
        need_rd       = 1'b0;
        pb_we         = 1'b0;
        res_data      = '0;
        res_target    = '0;
        res_store     = 1'b0;
        res_err       = fpsc_pkg::ERR_OK;
        unique case (in_mode_reg)
            fpsc_pkg::IN_COMMAND: begin
                unique case (opcode)
                    fpsc_pkg::OPC_SET_OFFSET: begin
                        page_off_next = po_cmd;
                    end
                    fpsc_pkg::OPC_ERASE: begin
                        op_mode_next = fpsc_pkg::OPM_ERASE;
                        status_next  = fpsc_pkg::STAT_ERASE;
                    end
                    fpsc_pkg::OPC_ERASE_OFFSET: begin
                        page_off_next = po_cmd;
                        status_next   = fpsc_pkg::STAT_ERASE_OFFSET;
                    end
                    fpsc_pkg::OPC_WRITE: begin
                        op_mode_next = fpsc_pkg::OPM_WRITE;
                    end
                    fpsc_pkg::OPC_EXECUTE: begin
                        op_mode_next = fpsc_pkg::OPM_IDLE;
                        unique case (op_mode_reg)
                            fpsc_pkg::OPM_ERASE: begin
                                if (po_ok) begin
                                    need_exec = 1'b1;
                                end else begin
                                    res_err = fpsc_pkg::ERR_RANGE;
                                end
                            end
                            fpsc_pkg::OPM_WRITE: begin
                                if (po_ok && sp_ok) begin
                                    need_exec = 1'b1;
                                end else begin
                                    res_err = fpsc_pkg::ERR_RANGE;
                                end
                            end
                            fpsc_pkg::OPM_READ: begin
                                res_err = fpsc_pkg::ERR_EXEC_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                    fpsc_pkg::OPC_STATUS: begin
                        op_mode_next = fpsc_pkg::OPM_STATUS;
                        status_next  = fpsc_pkg::STAT_STATUS;
                    end
                    fpsc_pkg::OPC_READ: begin
                        op_mode_next = fpsc_pkg::OPM_READ;
                        status_next  = fpsc_pkg::STAT_READ;
                    end
                    default: begin
                        res_err = fpsc_pkg::ERR_UNKNOWN;
                    end
                endcase
            end
            fpsc_pkg::IN_STATUS_HI: begin
                res_data = {32'h0, status_reg[63:32]};
            end
            fpsc_pkg::IN_DMA_READ: begin
                if (op_mode_reg == fpsc_pkg::OPM_STATUS) begin
                    if ({1'b0, dram_reg} <= StatLim) begin
                        res_data   = status_reg;
                        res_target = dram_reg;
                        res_store  = 1'b1;
                    end else begin
                        res_err = fpsc_pkg::ERR_RANGE;
                    end
                end else if (op_mode_reg == fpsc_pkg::OPM_READ) begin
                    if (rd_ok) begin
                        need_rd = 1'b1;
                    end else begin
                        res_err = fpsc_pkg::ERR_RANGE;
                    end
                end else begin
                    res_err = fpsc_pkg::ERR_BAD_READ;
                end
            end
            fpsc_pkg::IN_DMA_WRITE: begin
                if (op_mode_reg == fpsc_pkg::OPM_WRITE) begin
                    src_ptr_next = dram_reg;
                end else begin
                    res_err = fpsc_pkg::ERR_BAD_WRITE;
                end
            end
            fpsc_pkg::IN_PAGE_LOAD: begin
                pb_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg  <= fpsc_pkg::OPM_IDLE;
            status_reg   <= '0;
            page_off_reg <= '0;
            src_ptr_reg  <= '0;
        end else if (cmd.commit) begin
            op_mode_reg  <= op_mode_next;
            status_reg   <= status_next;
            page_off_reg <= page_off_next;
            src_ptr_reg  <= src_ptr_next;
        end
    end

    // Page copy: read buffer at exec_cnt, write flash in the cycle after
    logic [PA:0]   exec_cnt_reg;
    logic          wr_pend_reg;
    logic [PA-1:0] wr_idx_reg;
    logic          exec_erase_reg;
    logic          pb_re;

    assign pb_re = cmd.exec_en && !exec_cnt_reg[PA];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_cnt_reg <= '0;
            wr_pend_reg  <= 1'b0;
        end else begin
            wr_pend_reg <= pb_re;
            if (cmd.commit && need_exec) begin
                exec_cnt_reg <= '0;
            end else if (pb_re) begin
                exec_cnt_reg <= exec_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wr_idx_reg <= exec_cnt_reg[PA-1:0];
        if (cmd.commit && need_exec) begin
            exec_erase_reg <= (op_mode_reg == fpsc_pkg::OPM_ERASE);
        end
    end

    // Clearing pass address
    logic [FA-1:0] clear_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
        end else if (cmd.clear_en) begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // Page buffer
    logic [7:0] pb_rdata;

    fpsc_ram #(
        .WIDTH(8),
        .DEPTH(fpsc_pkg::PAGE_BYTES)
    ) u_page_buf (
        .clk  (aclk),
        .we   (cmd.commit && pb_we),
        .waddr(pidx_reg),
        .wdata(dbyte_reg),
        .re   (pb_re),
        .raddr(exec_cnt_reg[PA-1:0]),
        .rdata(pb_rdata)
    );

    // Flash store
    logic          fl_we;
    logic [FA-1:0] fl_waddr;
    logic [7:0]    fl_wdata;
    logic [7:0]    fl_rdata;

    assign fl_we    = cmd.clear_en || wr_pend_reg;
    assign fl_waddr = cmd.clear_en ? clear_cnt_reg
                                   : page_off_reg[FA-1:0] + FA'(wr_idx_reg);
    assign fl_wdata = (cmd.clear_en || exec_erase_reg) ? 8'hFF : pb_rdata;

    fpsc_ram #(
        .WIDTH(8),
        .DEPTH(FLASH_BYTES)
    ) u_flash (
        .clk  (aclk),
        .we   (fl_we),
        .waddr(fl_waddr),
        .wdata(fl_wdata),
        .re   (cmd.commit && need_rd),
        .raddr(rd_sum_flash[FA-1:0]),
        .rdata(fl_rdata)
    );

    // Output register
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [23:0] out_target_reg;
    logic        out_store_reg;
    logic [2:0]  out_err_reg;
    logic        out_load;

    assign out_load = cmd.commit && !need_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load || cmd.rd_capture) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg   <= res_data;
            out_target_reg <= res_target;
            out_store_reg  <= res_store;
            out_err_reg    <= res_err;
        end else if (cmd.rd_capture) begin
            out_data_reg   <= {56'h0, fl_rdata};
            out_target_reg <= rd_target;
            out_store_reg  <= 1'b1;
            out_err_reg    <= fpsc_pkg::ERR_OK;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_err_reg, out_store_reg, out_target_reg, out_data_reg};

    // Status to controller
    assign stat.clear_done = (clear_cnt_reg == FA'(FLASH_BYTES - 1));
    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.need_exec  = need_exec;
    assign stat.need_rd    = need_rd;
    assign stat.exec_done  = exec_cnt_reg[PA];

endmodule

// ----- design/fpsc_checker.sv -----
// Port-level checker for the flash page store controller, bound to the top level.
// Depends on fpsc_pkg and flash_page_store_controller.
module fpsc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [fpsc_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [fpsc_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fpsc_pkg::M_TDATA_W-1:0]  m_tdata
);

    // no result beat straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // one item in flight: intake closes right after an accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in decode");

    // no store address unless a store is requested
    a_target_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[88] |-> m_tdata[87:64] == 24'h0)
        else $error("dram_target set without store_enable");

    // an error never comes with a store
    a_err_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[91:89] != fpsc_pkg::ERR_OK |-> !m_tdata[88])
        else $error("store_enable set on an error result");

endmodule

bind flash_page_store_controller fpsc_checker u_fpsc_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for flash_page_store_controller: drives command, dma and page load beats,
// predicts each result beat from its own copy of the controller state and flash contents.
// Depends on fpsc_pkg and the flash_page_store_controller RTL.
module tb_top;

    localparam int FLASH_BYTES  = fpsc_pkg::FLASH_BYTES_DEF;
    localparam int RDRAM_BYTES  = fpsc_pkg::RDRAM_BYTES;
    localparam int PAGE_BYTES   = fpsc_pkg::PAGE_BYTES;
    localparam int STATUS_BYTES = fpsc_pkg::STATUS_BYTES;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 1450;

    // One input beat, field by field
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] command;
        logic [31:0] cart_addr;
        logic [23:0] dram_addr;
        logic [23:0] len_m1;
        logic [23:0] byte_idx;
        logic [6:0]  page_idx;
        logic [7:0]  data_byte;
    } flash_beat_t;

    // One result beat, laid out as m_tdata[91:0]
    typedef struct packed {
        logic [2:0]  err;
        logic        store;
        logic [23:0] target;
        logic [63:0] data;
    } flash_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [fpsc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [fpsc_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [fpsc_pkg::M_TDATA_W-1:0] m_tdata;

    flash_page_store_controller uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predicted controller state
    fpsc_pkg::opm_t fl_mode = fpsc_pkg::OPM_IDLE;
    logic [63:0] fl_status = '0;
    logic [22:0] fl_offset = '0;
    logic [23:0] fl_src_ptr = '0;
    logic [7:0]  flash_img [FLASH_BYTES];
    logic [7:0]  page_copy [PAGE_BYTES];
    bit          page_loaded [PAGE_BYTES];
    int          loaded_count = 0;

    flash_result_t pending_results [$];

    int fail_count = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int page_ops = 0;
    int byte_reads = 0;
    int status_reads = 0;
    int cycle_count = 0;

    // Sender burst control
    int burst_left = 0;
    bit idle_on = 1'b1;

    // Receiver hold-off requests
    int holds_requested = 0;
    int holds_started = 0;
    int hold_left = 0;
    int rx_style = 0;
    int rx_phase = 0;

    // Apply one beat to the predicted state and work out its result
    task automatic predict_flash_beat(input flash_beat_t b, output flash_result_t r);
        logic [31:0] cart_off;
        longint unsigned foff, span, dram_l;
        r = '0;
        case (b.kind)
            fpsc_pkg::IN_COMMAND: begin
                case (b.command[31:24])
                    fpsc_pkg::OPC_SET_OFFSET:
                        fl_offset = 23'(b.command[15:0] * PAGE_BYTES);
                    fpsc_pkg::OPC_ERASE: begin
                        fl_mode = fpsc_pkg::OPM_ERASE;
                        fl_status = fpsc_pkg::STAT_ERASE;
                    end
                    fpsc_pkg::OPC_ERASE_OFFSET: begin
                        fl_offset = 23'(b.command[15:0] * PAGE_BYTES);
                        fl_status = fpsc_pkg::STAT_ERASE_OFFSET;
                    end
                    fpsc_pkg::OPC_WRITE: fl_mode = fpsc_pkg::OPM_WRITE;
                    fpsc_pkg::OPC_EXECUTE: begin
                        if (fl_mode == fpsc_pkg::OPM_ERASE) begin
                            if (fl_offset > FLASH_BYTES - PAGE_BYTES) begin
                                r.err = fpsc_pkg::ERR_RANGE;
                            end else begin
                                for (int i = 0; i < PAGE_BYTES; i++)
                                    flash_img[fl_offset + i] = 8'hFF;
                                page_ops++;
                            end
                        end else if (fl_mode == fpsc_pkg::OPM_WRITE) begin
                            if (fl_offset > FLASH_BYTES - PAGE_BYTES ||
                                fl_src_ptr > RDRAM_BYTES - PAGE_BYTES) begin
                                r.err = fpsc_pkg::ERR_RANGE;
                            end else begin
                                for (int i = 0; i < PAGE_BYTES; i++)
                                    flash_img[fl_offset + i] = page_copy[i];
                                page_ops++;
                            end
                        end else if (fl_mode == fpsc_pkg::OPM_READ) begin
                            r.err = fpsc_pkg::ERR_EXEC_READ;
                        end
                        fl_mode = fpsc_pkg::OPM_IDLE;
                    end
                    fpsc_pkg::OPC_STATUS: begin
                        fl_mode = fpsc_pkg::OPM_STATUS;
                        fl_status = fpsc_pkg::STAT_STATUS;
                    end
                    fpsc_pkg::OPC_READ: begin
                        fl_mode = fpsc_pkg::OPM_READ;
                        fl_status = fpsc_pkg::STAT_READ;
                    end
                    default: r.err = fpsc_pkg::ERR_UNKNOWN;
                endcase
            end
            fpsc_pkg::IN_STATUS_HI: r.data = {32'h0, fl_status[63:32]};
            fpsc_pkg::IN_DMA_READ: begin
                if (fl_mode == fpsc_pkg::OPM_STATUS) begin
                    if (b.dram_addr <= RDRAM_BYTES - STATUS_BYTES) begin
                        r.data = fl_status;
                        r.target = b.dram_addr;
                        r.store = 1'b1;
                        status_reads++;
                    end else begin
                        r.err = fpsc_pkg::ERR_RANGE;
                    end
                end else if (fl_mode == fpsc_pkg::OPM_READ) begin
                    // flash offset is in 16-bit words from the window base
                    cart_off = b.cart_addr - fpsc_pkg::CART_BASE;
                    foff = longint'(cart_off[15:0]) * 2;
                    span = longint'(b.len_m1) + 1;
                    dram_l = longint'(b.dram_addr);
                    if (foff < FLASH_BYTES) begin
                        if (span > FLASH_BYTES - foff) span = FLASH_BYTES - foff;
                    end else begin
                        span = 0;
                    end
                    if (dram_l < RDRAM_BYTES) begin
                        if (span > RDRAM_BYTES - dram_l) span = RDRAM_BYTES - dram_l;
                    end else begin
                        span = 0;
                    end
                    if (longint'(b.byte_idx) < span) begin
                        r.data = {56'h0, flash_img[foff + b.byte_idx]};
                        r.target = b.dram_addr + b.byte_idx;
                        r.store = 1'b1;
                        byte_reads++;
                    end else begin
                        r.err = fpsc_pkg::ERR_RANGE;
                    end
                end else begin
                    r.err = fpsc_pkg::ERR_BAD_READ;
                end
            end
            fpsc_pkg::IN_DMA_WRITE: begin
                if (fl_mode == fpsc_pkg::OPM_WRITE) fl_src_ptr = b.dram_addr;
                else r.err = fpsc_pkg::ERR_BAD_WRITE;
            end
            fpsc_pkg::IN_PAGE_LOAD: begin
                page_copy[b.page_idx] = b.data_byte;
                if (!page_loaded[b.page_idx]) begin
                    page_loaded[b.page_idx] = 1'b1;
                    loaded_count++;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one beat, wait for the handshake, record its expected result
    task automatic push_beat(input flash_beat_t b);
        flash_result_t r;
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= b.kind;
        s_tdata <= {1'b0, b.data_byte, b.page_idx, b.byte_idx, b.len_m1,
                    b.dram_addr, b.cart_addr, b.command};
        do @(posedge aclk); while (!s_tready);
        predict_flash_beat(b, r);
        pending_results.push_back(r);
        beats_sent++;
        // burst / gap pacing
        if (burst_left > 0) begin
            burst_left--;
        end else if (idle_on) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // A program never reads a page buffer entry that was never loaded
    task automatic send_item(input flash_beat_t b);
        flash_beat_t fill;
        if (b.kind == fpsc_pkg::IN_COMMAND && b.command[31:24] == fpsc_pkg::OPC_EXECUTE &&
            fl_mode == fpsc_pkg::OPM_WRITE && loaded_count < PAGE_BYTES) begin
            for (int i = 0; i < PAGE_BYTES; i++) begin
                if (!page_loaded[i]) begin
                    fill = random_beat();
                    fill.kind = fpsc_pkg::IN_PAGE_LOAD;
                    fill.page_idx = 7'(i);
                    push_beat(fill);
                end
            end
        end
        push_beat(b);
    endtask

    function automatic flash_beat_t random_beat();
        flash_beat_t b;
        b.kind = 3'($urandom_range(0, 7));
        b.command = $urandom;
        b.cart_addr = $urandom;
        b.dram_addr = 24'($urandom);
        b.len_m1 = 24'($urandom);
        b.byte_idx = 24'($urandom);
        b.page_idx = 7'($urandom);
        b.data_byte = 8'($urandom);
        return b;
    endfunction

    function automatic logic [15:0] pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(0, 31));
        if (r < 95) return 16'($urandom_range(0, 1023));
        return 16'($urandom);
    endfunction

    task automatic send_command(input logic [7:0] opc, input logic [15:0] page);
        flash_beat_t b;
        b = random_beat();
        b.kind = fpsc_pkg::IN_COMMAND;
        b.command = {opc, b.command[23:16], page};
        send_item(b);
    endtask

    task automatic send_status_high();
        flash_beat_t b;
        b = random_beat();
        b.kind = fpsc_pkg::IN_STATUS_HI;
        send_item(b);
    endtask

    task automatic send_dma_read(input logic [31:0] cart, input logic [23:0] dram,
                                 input logic [23:0] lenm1, input logic [23:0] bidx);
        flash_beat_t b;
        b = random_beat();
        b.kind = fpsc_pkg::IN_DMA_READ;
        b.cart_addr = cart;
        b.dram_addr = dram;
        b.len_m1 = lenm1;
        b.byte_idx = bidx;
        send_item(b);
    endtask

    task automatic send_dma_write(input logic [23:0] dram);
        flash_beat_t b;
        b = random_beat();
        b.kind = fpsc_pkg::IN_DMA_WRITE;
        b.dram_addr = dram;
        send_item(b);
    endtask

    task automatic send_page_load(input logic [6:0] idx, input logic [7:0] value);
        flash_beat_t b;
        b = random_beat();
        b.kind = fpsc_pkg::IN_PAGE_LOAD;
        b.page_idx = idx;
        b.data_byte = value;
        send_item(b);
    endtask

    // Field extremes, every opcode except write, and the error paths
    task automatic test_directed_cases();
        flash_beat_t b;
        send_status_high();
        send_command(8'h00, 16'h0000);
        send_command(8'hFF, 16'hFFFF);
        send_dma_read($urandom, 24'h0, 24'h0, 24'h0);
        send_dma_write(24'hFFFFFF);
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
        // status mode: full word at the RDRAM edge
        send_command(fpsc_pkg::OPC_STATUS, 16'h0);
        send_dma_read($urandom, 24'h0, 24'($urandom), 24'hFFFFFF);
        send_dma_read($urandom, 24'(RDRAM_BYTES - STATUS_BYTES), 24'($urandom), 24'h0);
        send_dma_read($urandom, 24'(RDRAM_BYTES - STATUS_BYTES + 1), 24'($urandom), 24'h0);
        send_dma_read($urandom, 24'hFFFFFF, 24'($urandom), 24'h0);
        send_status_high();
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
        // read mode: length clamps on flash end and RDRAM end
        send_command(fpsc_pkg::OPC_READ, 16'h0);
        send_dma_read(fpsc_pkg::CART_BASE, 24'h0, 24'h0, 24'h0);
        send_dma_read(fpsc_pkg::CART_BASE, 24'h0, 24'h0, 24'h1);
        send_dma_read(fpsc_pkg::CART_BASE + 32'hFFFF, 24'h100, 24'hFFFFFF, 24'h1);
        send_dma_read(fpsc_pkg::CART_BASE + 32'hFFFF, 24'h100, 24'hFFFFFF, 24'h2);
        send_dma_read(fpsc_pkg::CART_BASE, 24'(RDRAM_BYTES - 1), 24'd10, 24'h1);
        send_dma_read(32'h0, 24'hFFFFFF, 24'h0, 24'h0);
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
        // erase: page past the end, last page, first page past the end
        send_command(fpsc_pkg::OPC_SET_OFFSET, 16'hFFFF);
        send_command(fpsc_pkg::OPC_ERASE, 16'h0);
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
        send_command(fpsc_pkg::OPC_ERASE_OFFSET, 16'd1023);
        send_command(fpsc_pkg::OPC_ERASE, 16'h0);
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
        send_command(fpsc_pkg::OPC_SET_OFFSET, 16'd1024);
        send_command(fpsc_pkg::OPC_ERASE, 16'h0);
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
        // unused kinds are ignored
        for (int k = 5; k < 8; k++) begin
            b = random_beat();
            b.kind = 3'(k);
            send_item(b);
        end
    endtask

    // Full page program, read back, and source pointer bounds
    task automatic test_page_program();
        send_command(fpsc_pkg::OPC_WRITE, 16'h0);
        send_dma_write(24'(RDRAM_BYTES - PAGE_BYTES));
        for (int i = 0; i < PAGE_BYTES; i++)
            send_page_load(7'(i), (i == 0) ? 8'h00 :
                                  (i == PAGE_BYTES - 1) ? 8'hFF : 8'($urandom));
        send_command(fpsc_pkg::OPC_SET_OFFSET, 16'h0);
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
        send_command(fpsc_pkg::OPC_READ, 16'h0);
        for (int i = 0; i < 6; i++)
            send_dma_read(fpsc_pkg::CART_BASE + 32'(i * 11), 24'($urandom_range(0, 4095)),
                          24'd255, 24'(i * 7));
        send_command(fpsc_pkg::OPC_WRITE, 16'h0);
        send_dma_write(24'(RDRAM_BYTES - PAGE_BYTES + 1));
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
        send_command(fpsc_pkg::OPC_SET_OFFSET, 16'd1023);
        send_command(fpsc_pkg::OPC_WRITE, 16'h0);
        send_dma_write(24'h0);
        send_command(fpsc_pkg::OPC_EXECUTE, 16'h0);
    endtask

    // Mostly well-formed command sequences with random content, some noise
    task automatic test_random_traffic(input int until_beats);
        flash_beat_t b;
        int pick, n, r;
        logic [7:0] opcodes [7];
        logic [31:0] cart;
        logic [23:0] dram, lenm1, bidx;
        opcodes = '{fpsc_pkg::OPC_SET_OFFSET, fpsc_pkg::OPC_ERASE,
                    fpsc_pkg::OPC_ERASE_OFFSET, fpsc_pkg::OPC_WRITE,
                    fpsc_pkg::OPC_EXECUTE, fpsc_pkg::OPC_STATUS, fpsc_pkg::OPC_READ};
        while (beats_sent < until_beats) begin
            if ($urandom_range(0, 99) < 3) idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // page erase
                send_command($urandom_range(0, 1) ? fpsc_pkg::OPC_SET_OFFSET
                                                  : fpsc_pkg::OPC_ERASE_OFFSET,
                             pick_page());
                send_command(fpsc_pkg::OPC_ERASE, 16'($urandom));
                send_command(fpsc_pkg::OPC_EXECUTE, 16'($urandom));
            end else if (pick < 35) begin
                // page program
                send_command(fpsc_pkg::OPC_WRITE, 16'($urandom));
                send_dma_write(($urandom_range(0, 99) < 85) ?
                               24'($urandom_range(0, RDRAM_BYTES - PAGE_BYTES)) :
                               24'($urandom));
                repeat ($urandom_range(1, 16)) send_page_load(7'($urandom), 8'($urandom));
                send_command(fpsc_pkg::OPC_SET_OFFSET, pick_page());
                send_command(fpsc_pkg::OPC_EXECUTE, 16'($urandom));
            end else if (pick < 55) begin
                // flash byte reads
                send_command(fpsc_pkg::OPC_READ, 16'($urandom));
                n = $urandom_range(2, 10);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    cart = (r < 85) ? fpsc_pkg::CART_BASE + $urandom_range(0, 2047)
                                    : $urandom;
                    r = $urandom_range(0, 99);
                    dram = (r < 90) ? 24'($urandom_range(0, 65535)) :
                           (r < 95) ? 24'(RDRAM_BYTES - $urandom_range(1, 64)) :
                                      24'($urandom);
                    lenm1 = ($urandom_range(0, 99) < 85) ? 24'($urandom_range(0, 255))
                                                         : 24'($urandom);
                    bidx = ($urandom_range(0, 99) < 80) ? 24'($urandom_range(0, 300))
                                                        : 24'($urandom);
                    send_dma_read(cart, dram, lenm1, bidx);
                end
            end else if (pick < 65) begin
                // status word reads
                send_command(fpsc_pkg::OPC_STATUS, 16'($urandom));
                send_status_high();
                repeat ($urandom_range(1, 3)) begin
                    r = $urandom_range(0, 99);
                    dram = (r < 80) ? 24'($urandom_range(0, RDRAM_BYTES - STATUS_BYTES)) :
                           (r < 90) ? 24'(RDRAM_BYTES - $urandom_range(0, 15)) :
                                      24'($urandom);
                    send_dma_read($urandom, dram, 24'($urandom), 24'($urandom));
                end
            end else if (pick < 80) begin
                // single valid command from whatever mode we are in
                send_command(opcodes[$urandom_range(0, 6)], pick_page());
                if ($urandom_range(0, 1)) send_dma_write(24'($urandom));
            end else begin
                // noise
                b = random_beat();
                if ($urandom_range(0, 99) < 30) b.command[31:24] = opcodes[$urandom_range(0, 6)];
                send_item(b);
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle = idle_on;
        idle_on = 1'b0;
        holds_requested++;
        send_command(fpsc_pkg::OPC_READ, 16'h0);
        for (int i = 0; i < 40; i++)
            send_dma_read(fpsc_pkg::CART_BASE + $urandom_range(0, 2047),
                          24'($urandom_range(0, 4095)), 24'($urandom_range(0, 127)),
                          24'($urandom_range(0, 140)));
        idle_on = saved_idle;
    endtask

    // Receiver stall pattern, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_started != holds_requested) begin
            holds_started++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_phase = $urandom_range(16, 96);
            end
            rx_phase--;
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= ((rx_phase % 5) < 2);
            endcase
        end
    end

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    // Result checker
    always @(posedge aclk) begin
        flash_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[91:0];
            results_seen++;
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: result beat mismatch, expected none, got %0h", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data) note_mismatch("data_out", want.data, got.data);
                if (got.target !== want.target)
                    note_mismatch("dram_target", 64'(want.target), 64'(got.target));
                if (got.store !== want.store)
                    note_mismatch("store_enable", 64'(want.store), 64'(got.store));
                if (got.err !== want.err)
                    note_mismatch("error_code", 64'(want.err), 64'(got.err));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("** flash_page_store_controller: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < FLASH_BYTES; i++) flash_img[i] = 8'hFF;
        for (int i = 0; i < PAGE_BYTES; i++) begin
            page_copy[i] = 8'h00;
            page_loaded[i] = 1'b0;
        end
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_page_program();
        test_random_traffic(ITEM_TARGET / 2);
        test_backpressure();
        test_random_traffic(ITEM_TARGET);

        // drain, then let a trailing page operation finish
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PAGE_BYTES + 16) @(posedge aclk);

        $display("Covered %0d beats and %0d results: %0d page erase/program runs,",
                 beats_sent, results_seen, page_ops);
        $display("%0d flash byte reads, %0d status word reads, %0d receiver hold-offs.",
                 byte_reads, status_reads, holds_started);
        if (fail_count == 0) begin
            $display("** flash_page_store_controller: PASSED **");
        end else begin
            $display("** flash_page_store_controller: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/fpsc_pkg.sv
design/fpsc_ram.sv
design/fpsc_ctrl.sv
design/fpsc_dp.sv
design/flash_page_store_controller.sv
design/fpsc_checker.sv
test/tb_top.sv
